@@ sv/brfa_pkg.sv @@
`default_nettype none

package brfa_pkg;

	// command codes
	localparam logic [2:0] CMD_RD_REG    = 3'd0;
	localparam logic [2:0] CMD_WR_REG    = 3'd1;
	localparam logic [2:0] CMD_RD_FLAGS  = 3'd2;
	localparam logic [2:0] CMD_WR_FLAGS  = 3'd3;
	localparam logic [2:0] CMD_RD_STATUS = 3'd4;
	localparam logic [2:0] CMD_WR_STATUS = 3'd5;
	localparam logic [2:0] CMD_RD_PC     = 3'd6;
	localparam logic [2:0] CMD_WR_PC     = 3'd7;

	// access sizes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;
	localparam logic [1:0] SIZE_LONG = 2'd2;
	localparam logic [1:0] SIZE_BAD  = 2'd3;

	// high nibble of the register code for the windowed regions
	localparam logic [3:0] REGION_PREV  = 4'hd;
	localparam logic [3:0] REGION_CUR   = 4'he;
	localparam logic [3:0] REGION_INDEX = 4'hf;

	// status word bits that always read as one (bits 11 and 15)
	localparam logic [15:0] STATUS_FIXED = 16'h8800;

	// decoded register access
	typedef struct packed {
		logic       hit;
		logic       is_index;
		logic [3:0] bank_idx;
		logic [1:0] idx_sel;
		logic [3:0] byte_en;
		logic [4:0] shift;
	} brfa_dec_t;

	// flag set c,n,v,h,z,s to its byte image
	function automatic logic [7:0] flags_to_byte(input logic [5:0] f);
		return {f[5], f[4], 1'b0, f[3], 1'b0, f[2], f[1], f[0]};
	endfunction

	// byte image back to the packed flag set
	function automatic logic [5:0] byte_to_flags(input logic [7:0] b);
		return {b[7], b[6], b[4], b[2], b[1], b[0]};
	endfunction

endpackage

`default_nettype wire

@@ sv/brfa_decode.sv @@
`default_nettype none

module brfa_decode import brfa_pkg::*; (
	input  wire logic [7:0] register_code,
	input  wire logic [1:0] access_size,
	input  wire logic [1:0] bank_pointer,
	output brfa_dec_t       dec
);

	logic [1:0] reg_sel;
	logic [1:0] prev_bank;
	logic [1:0] lane;

	assign reg_sel   = register_code[3:2];
	assign prev_bank = bank_pointer - 2'd1;

	// region decode
	always_comb begin
		dec.hit      = 1'b1;
		dec.is_index = 1'b0;
		dec.bank_idx = {register_code[5:4], reg_sel};
		dec.idx_sel  = reg_sel;
		if (register_code[7:6] == 2'b00) begin
			dec.bank_idx = {register_code[5:4], reg_sel};
		end else if (register_code[7:4] == REGION_PREV) begin
			dec.bank_idx = {prev_bank, reg_sel};
		end else if (register_code[7:4] == REGION_CUR) begin
			dec.bank_idx = {bank_pointer, reg_sel};
		end else if (register_code[7:4] == REGION_INDEX) begin
			dec.is_index = 1'b1;
		end else begin
			dec.hit = 1'b0;
		end
		if (access_size == SIZE_BAD) begin
			dec.hit = 1'b0;
		end

		// byte lane select
		lane = 2'd0;
		dec.byte_en = 4'b1111;
		unique case (access_size)
			SIZE_BYTE: begin
				lane = register_code[1:0];
				dec.byte_en = 4'b0001 << register_code[1:0];
			end
			SIZE_WORD: begin
				lane = {register_code[1], 1'b0};
				dec.byte_en = register_code[1] ? 4'b1100 : 4'b0011;
			end
			SIZE_LONG: begin
				lane = 2'd0;
				dec.byte_en = 4'b1111;
			end
			SIZE_BAD: begin
				lane = 2'd0;
				dec.byte_en = 4'b0000;
			end
		endcase
		dec.shift = {lane, 3'b000};
	end

endmodule

`default_nettype wire

@@ sv/banked_register_file_access_unit.sv @@
// banked register file access unit
//
// input channel s_*: one access per transaction. s_tuser carries the command,
// s_tdata the access size, register code, flag set select and write data.
// output channel m_*: one result per access, m_tdata is the read value
// (zero for writes and misses), m_tuser flags a mapped register.
// path: the access register captures the input transaction; the access is then
// decoded, reads or updates the register state and loads the result register,
// which offers the result.
// throughput: one access per cycle while the receiver does not stall, set by
// the single decode and byte-lane path between the access register and the
// result register; an access issued right after a write sees the written value.
// when the receiver stalls, the result register holds and the access
// register holds behind it, so s_tready drops only while both are full.
// reset clears all banks, index registers, both flag sets, bank pointer,
// interrupt mask and program counter to zero and empties both registers.
`default_nettype none

module banked_register_file_access_unit import brfa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] access_size, [9:2] register_code, [10] flag_set,
	// [42:11] write_data, [47:43] zero
	input  wire logic [47:0] s_tdata,
	// [2:0] command
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] read_data
	output logic [31:0]      m_tdata,
	// [0] mapped
	output logic [0:0]       m_tuser
);

	// access register
	logic        valid_s1;
	logic [2:0]  command_s1;
	logic [1:0]  size_s1;
	logic [7:0]  code_s1;
	logic        fset_s1;
	logic [31:0] wdata_s1;

	// result register
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_mapped_q;

	// register state
	logic [31:0] bank_q [16];
	logic [31:0] index_q [4];
	logic [5:0]  main_flags_q;
	logic [5:0]  alt_flags_q;
	logic [1:0]  bank_pointer_q;
	logic [2:0]  int_mask_q;
	logic [31:0] pc_q;

	logic        advance;
	brfa_dec_t   dec;
	logic [31:0] sel_reg;
	logic [31:0] lane_mask;
	logic [31:0] reg_rd;
	logic [31:0] reg_wr;
	logic [31:0] rd_data;
	logic        rd_mapped;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			size_s1    <= s_tdata[1:0];
			code_s1    <= s_tdata[9:2];
			fset_s1    <= s_tdata[10];
			wdata_s1   <= s_tdata[42:11];
		end
	end

	brfa_decode u_decode (
		.register_code (code_s1),
		.access_size   (size_s1),
		.bank_pointer  (bank_pointer_q),
		.dec           (dec)
	);

	// byte lane read and merge
	assign sel_reg   = dec.is_index ? index_q[dec.idx_sel] : bank_q[dec.bank_idx];
	assign lane_mask = {{8{dec.byte_en[3]}}, {8{dec.byte_en[2]}},
		{8{dec.byte_en[1]}}, {8{dec.byte_en[0]}}};
	assign reg_rd    = (sel_reg & lane_mask) >> dec.shift;
	assign reg_wr    = (sel_reg & ~lane_mask) | ((wdata_s1 << dec.shift) & lane_mask);

	// result value per command
	always_comb begin
		rd_data   = 32'd0;
		rd_mapped = 1'b1;
		unique case (command_s1)
			CMD_RD_REG: begin
				rd_mapped = dec.hit;
				rd_data   = dec.hit ? reg_rd : 32'd0;
			end
			CMD_WR_REG: begin
				rd_mapped = dec.hit;
			end
			CMD_RD_FLAGS: begin
				rd_data = {24'd0, flags_to_byte(fset_s1 ? alt_flags_q : main_flags_q)};
			end
			CMD_RD_STATUS: begin
				rd_data = {16'd0, STATUS_FIXED | {1'b0, int_mask_q, 2'b00, bank_pointer_q,
					flags_to_byte(main_flags_q)}};
			end
			CMD_RD_PC: begin
				rd_data = pc_q;
			end
			CMD_WR_FLAGS, CMD_WR_STATUS, CMD_WR_PC: begin
				rd_data = 32'd0;
			end
		endcase
	end

	// state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				bank_q[i] <= 32'd0;
			end
			for (int i = 0; i < 4; i++) begin
				index_q[i] <= 32'd0;
			end
			main_flags_q   <= 6'd0;
			alt_flags_q    <= 6'd0;
			bank_pointer_q <= 2'd0;
			int_mask_q     <= 3'd0;
			pc_q           <= 32'd0;
		end else if (advance) begin
			if (command_s1 == CMD_WR_REG && dec.hit) begin
				if (dec.is_index) begin
					index_q[dec.idx_sel] <= reg_wr;
				end else begin
					bank_q[dec.bank_idx] <= reg_wr;
				end
			end
			if (command_s1 == CMD_WR_FLAGS) begin
				if (fset_s1) begin
					alt_flags_q <= byte_to_flags(wdata_s1[7:0]);
				end else begin
					main_flags_q <= byte_to_flags(wdata_s1[7:0]);
				end
			end
			if (command_s1 == CMD_WR_STATUS) begin
				main_flags_q   <= byte_to_flags(wdata_s1[7:0]);
				bank_pointer_q <= wdata_s1[9:8];
				int_mask_q     <= wdata_s1[14:12];
			end
			if (command_s1 == CMD_WR_PC) begin
				pc_q <= wdata_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q   <= rd_data;
			out_mapped_q <= rd_mapped;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_mapped_q;

`ifndef SYNTHESIS
	// input stalls only when both registers are full and the output is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a full pipeline");

	// every write returns zero data
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (command_s1 == CMD_WR_REG || command_s1 == CMD_WR_FLAGS ||
		command_s1 == CMD_WR_STATUS || command_s1 == CMD_WR_PC)) |=> (m_tdata == 32'd0))
		else $error("write transaction returned nonzero data");

	// a miss reads as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("unmapped access returned nonzero data");

	// bank pointer moves only through a status write
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bank_pointer_q) |-> $past(advance && command_s1 == CMD_WR_STATUS))
		else $error("bank pointer changed without a status write");

	// the program counter moves only through a pc write
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pc_q) |-> $past(advance && command_s1 == CMD_WR_PC))
		else $error("program counter changed without a pc write");
`endif

endmodule

`default_nettype wire
